>>> rtl/core/tics_pkg.sv
// tics_pkg: shared types, constants and small tables for the track isolation cone sum
// used by tics_front, tics_queue, tics_back and track_isolation_cone_sum
package tics_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [23:0]        PT_MIN     = 24'd256;
  localparam logic signed [19:0] PI_Q16     = 20'sd205887;
  localparam logic signed [19:0] PI_Q12_Z   = 20'sd12868;
  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic [15:0]        LN2_Q16    = 16'd45426;
  localparam logic [14:0]        ETA_MAX    = 15'd32767;
  localparam logic [31:0]        U32_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_REF    = 2'd0,
    ACT_CAND   = 2'd1,
    ACT_FIN    = 2'd2,
    ACT_IGNORE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_OUTER    = 2'd0,
    REG_INNER    = 2'd1,
    REG_RELATIVE = 2'd2,
    REG_CUT      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] outer_radius;
    logic [15:0] inner_radius;
    logic        relative_mode;
    logic [31:0] isolation_cut;
  } cfg_t;

  typedef struct packed {
    action_t            action;
    logic               last_track;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic [23:0]        ax;
    logic [23:0]        ay;
    logic [23:0]        az;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // cordic angle table, units of 2^-16 rad
  function automatic logic [15:0] atan_q16(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] msb_index(input logic [24:0] v);
    logic [4:0] k;
    k = 5'd0;
    for (int b = 0; b < 25; b++) begin
      if (v[b]) k = 5'(b);
    end
    return k;
  endfunction

endpackage

>>> rtl/core/tics_front.sv
// tics_front: input stage, decodes the action and takes the momentum magnitudes
// depends on tics_pkg
module tics_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [71:0]         in_data,
  input  logic [1:0]          in_user,
  input  logic                in_last,
  output logic                push,
  output tics_pkg::item_t     push_item,
  input  tics_pkg::q_stat_t   q_stat
);

  logic              stage_valid;
  tics_pkg::item_t   stage;
  tics_pkg::item_t   dec;
  tics_pkg::action_t act;
  logic              accept;

  assign act = tics_pkg::action_t'(in_user);

  always_comb begin
    dec.action     = act;
    dec.last_track = in_last;
    dec.px         = $signed(in_data[23:0]);
    dec.py         = $signed(in_data[47:24]);
    dec.pz         = $signed(in_data[71:48]);
    dec.ax         = in_data[23] ? 24'(-in_data[23:0])  : in_data[23:0];
    dec.ay         = in_data[47] ? 24'(-in_data[47:24]) : in_data[47:24];
    dec.az         = in_data[71] ? 24'(-in_data[71:48]) : in_data[71:48];
  end

  assign push      = stage_valid && !q_stat.full;
  assign in_ready  = !stage_valid || !q_stat.full;
  assign accept    = in_valid && in_ready;
  assign push_item = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      // unused action code is dropped here
      stage_valid <= (act != tics_pkg::ACT_IGNORE);
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= dec;
    end
  end

endmodule

>>> rtl/core/tics_queue.sv
// tics_queue: short register fifo between the front stage and the sequencer
// depends on tics_pkg
module tics_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tics_pkg::item_t   push_item,
  input  logic              pop,
  output logic              pop_valid,
  output tics_pkg::item_t   pop_item,
  output tics_pkg::q_stat_t stat
);

  tics_pkg::item_t              mem [tics_pkg::QUEUE_DEPTH];
  logic [tics_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [tics_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [tics_pkg::QUEUE_AW:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign stat.full  = (count == (tics_pkg::QUEUE_AW+1)'(tics_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_valid  = !stat.empty;
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/core/tics_back.sv
// tics_back: sequencer with shared iterative units (square root, cordic, log2, divider)
// depends on tics_pkg
module tics_back (
  input  logic              clk,
  input  logic              rst,
  input  tics_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  tics_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_sum,
  output logic              out_iso,
  output logic              out_sat
);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_SQ    = 13'b0000000000010,
    ST_ROOT  = 13'b0000000000100,
    ST_PHI   = 13'b0000000001000,
    ST_LOGI  = 13'b0000000010000,
    ST_LOG   = 13'b0000000100000,
    ST_ETA   = 13'b0000001000000,
    ST_STORE = 13'b0000010000000,
    ST_DR    = 13'b0000100000000,
    ST_ACC   = 13'b0001000000000,
    ST_FIN   = 13'b0010000000000,
    ST_DIV   = 13'b0100000000000,
    ST_OUT   = 13'b1000000000000
  } state_t;

  state_t          state;
  logic [5:0]      cnt;
  tics_pkg::item_t item;

  logic [47:0] sq_xy, sq_z, root_n;
  logic [25:0] rem_r;
  logic [23:0] root;
  logic        root_p;
  logic [23:0] pt_r;
  logic [24:0] a_r;

  logic signed [35:0] cx, cy;
  logic signed [19:0] cz;
  logic signed [15:0] phi_r, eta_r;

  logic [30:0] log_y;
  logic [4:0]  log_k;
  logic [15:0] frac;
  logic        log_sel;
  logic [20:0] la;

  logic [34:0] dr2;
  logic [31:0] o2, i2;

  logic signed [15:0] ref_eta, ref_phi;
  logic [23:0]        ref_pt;
  logic [31:0]        acc;
  logic               clip;

  logic [47:0] div_n, div_q;
  logic [23:0] div_rem;
  logic [31:0] res_r;
  logic        sat_r;

  // squares of the momentum magnitudes
  logic [23:0] sq_op;
  logic [47:0] sq_prod;
  always_comb begin
    case (cnt[1:0])
      2'd0:    sq_op = item.ax;
      2'd1:    sq_op = item.ay;
      default: sq_op = item.az;
    endcase
    sq_prod = sq_op * sq_op;
  end

  // one digit of the integer square root
  logic [27:0] rem_sh;
  logic [25:0] trial;
  logic        root_ge;
  logic [25:0] rem_next;
  logic [23:0] root_next;
  always_comb begin
    rem_sh    = {rem_r, root_n[47:46]};
    trial     = {root, 2'b01};
    root_ge   = rem_sh >= {2'b00, trial};
    rem_next  = root_ge ? 26'(rem_sh - {2'b00, trial}) : rem_sh[25:0];
    root_next = {root[22:0], root_ge};
  end

  // cordic vectoring step
  logic signed [35:0] cx_sh, cy_sh, cx_next, cy_next;
  logic signed [19:0] cz_next, z_rnd;
  logic signed [15:0] phi_next;
  always_comb begin
    cx_sh = cx >>> cnt[3:0];
    cy_sh = cy >>> cnt[3:0];
    if (!cy[35]) begin
      cx_next = cx + cy_sh;
      cy_next = cy - cx_sh;
      cz_next = cz + $signed({4'b0, tics_pkg::atan_q16(cnt[3:0])});
    end else begin
      cx_next = cx - cy_sh;
      cy_next = cy + cx_sh;
      cz_next = cz - $signed({4'b0, tics_pkg::atan_q16(cnt[3:0])});
    end
    z_rnd = (cz_next + 20'sd8) >>> 4;
    if (item.px == '0 && item.py == '0) phi_next = '0;
    else if (z_rnd > tics_pkg::PI_Q12_Z)  phi_next = 16'(tics_pkg::PI_Q12_Z);
    else if (z_rnd < -tics_pkg::PI_Q12_Z) phi_next = 16'(-tics_pkg::PI_Q12_Z);
    else phi_next = z_rnd[15:0];
  end

  // log2 by repeated squaring
  logic [24:0] log_src;
  logic [4:0]  log_k0;
  logic [61:0] lsq;
  logic [31:0] ys;
  logic [30:0] log_y_next;
  logic [15:0] frac_next;
  always_comb begin
    log_src    = log_sel ? {1'b0, pt_r} : a_r;
    log_k0     = tics_pkg::msb_index(log_src);
    lsq        = log_y * log_y;
    ys         = lsq[61:30];
    log_y_next = ys[31] ? ys[31:1] : ys[30:0];
    frac_next  = {frac[14:0], ys[31]};
  end

  // eta from the log difference
  logic signed [21:0] ld;
  logic [20:0]        ld_pos;
  logic [36:0]        eta_prod;
  logic [14:0]        eta_mag;
  logic signed [15:0] eta_next;
  always_comb begin
    ld       = $signed({1'b0, la}) - $signed({1'b0, log_k, frac});
    ld_pos   = ld[21] ? '0 : ld[20:0];
    eta_prod = ld_pos * tics_pkg::LN2_Q16;
    eta_mag  = (eta_prod[36:20] > {2'b0, tics_pkg::ETA_MAX}) ? tics_pkg::ETA_MAX
                                                              : eta_prod[34:20];
    eta_next = item.pz[23] ? -$signed({1'b0, eta_mag}) : $signed({1'b0, eta_mag});
  end

  // deltaR terms, azimuth wrapped to plus or minus pi
  logic signed [17:0] deta, dphi_raw, dphi, dr_op;
  logic signed [35:0] dr_prod;
  always_comb begin
    deta     = {{2{eta_r[15]}}, eta_r} - {{2{ref_eta[15]}}, ref_eta};
    dphi_raw = {{2{phi_r[15]}}, phi_r} - {{2{ref_phi[15]}}, ref_phi};
    if (dphi_raw > tics_pkg::PI_Q12)       dphi = dphi_raw - tics_pkg::TWO_PI_Q12;
    else if (dphi_raw < -tics_pkg::PI_Q12) dphi = dphi_raw + tics_pkg::TWO_PI_Q12;
    else                                   dphi = dphi_raw;
    case (cnt[1:0])
      2'd0:    dr_op = deta;
      2'd1:    dr_op = dphi;
      2'd2:    dr_op = $signed({2'b00, cfg.outer_radius});
      default: dr_op = $signed({2'b00, cfg.inner_radius});
    endcase
    dr_prod = dr_op * dr_op;
  end

  logic [32:0] acc_sum;
  assign acc_sum = {1'b0, acc} + {9'b0, pt_r};

  // restoring divider step
  logic [24:0] drem_sh;
  logic        div_ge;
  logic [23:0] div_rem_next;
  logic [47:0] div_q_next;
  always_comb begin
    drem_sh      = {div_rem, div_n[47]};
    div_ge       = drem_sh >= {1'b0, ref_pt};
    div_rem_next = div_ge ? 24'(drem_sh - {1'b0, ref_pt}) : drem_sh[23:0];
    div_q_next   = {div_q[46:0], div_ge};
  end

  logic out_load;
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      ref_eta <= '0;
      ref_phi <= '0;
      ref_pt  <= '0;
      acc     <= '0;
      clip    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            item <= q_item;
            cnt  <= '0;
            if (q_item.action == tics_pkg::ACT_FIN) state <= ST_FIN;
            else                                    state <= ST_SQ;
          end
        end
        ST_SQ: begin
          cnt <= cnt + 1'b1;
          case (cnt[1:0])
            2'd0:    sq_xy <= sq_prod;
            2'd1:    sq_xy <= sq_xy + sq_prod;
            default: begin
              sq_z   <= sq_prod;
              root_n <= sq_xy;
              rem_r  <= '0;
              root   <= '0;
              root_p <= 1'b0;
              cnt    <= '0;
              state  <= ST_ROOT;
            end
          endcase
        end
        ST_ROOT: begin
          rem_r  <= rem_next;
          root   <= root_next;
          root_n <= {root_n[45:0], 2'b00};
          cnt    <= cnt + 1'b1;
          if (cnt == 6'd23) begin
            cnt <= '0;
            if (!root_p) begin
              pt_r <= root_next;
              if (item.action == tics_pkg::ACT_CAND && root_next < tics_pkg::PT_MIN) begin
                state <= item.last_track ? ST_FIN : ST_IDLE;
              end else begin
                // left half plane is folded over by pi
                if (item.px[23]) begin
                  cx <= $signed({4'b0, item.ax, 8'b0});
                  cy <= -$signed({{4{item.py[23]}}, item.py, 8'b0});
                  cz <= item.py[23] ? -tics_pkg::PI_Q16 : tics_pkg::PI_Q16;
                end else begin
                  cx <= $signed({4'b0, item.ax, 8'b0});
                  cy <= $signed({{4{item.py[23]}}, item.py, 8'b0});
                  cz <= '0;
                end
                state <= ST_PHI;
              end
            end else begin
              a_r     <= {1'b0, item.az} + {1'b0, root_next};
              log_sel <= 1'b0;
              state   <= ST_LOGI;
            end
          end
        end
        ST_PHI: begin
          cx  <= cx_next;
          cy  <= cy_next;
          cz  <= cz_next;
          cnt <= cnt + 1'b1;
          if (cnt == 6'd15) begin
            cnt   <= '0;
            phi_r <= phi_next;
            if (pt_r == '0) begin
              // reference with no transverse momentum
              if (item.pz == '0)      eta_r <= '0;
              else if (item.pz[23])   eta_r <= -$signed({1'b0, tics_pkg::ETA_MAX});
              else                    eta_r <= $signed({1'b0, tics_pkg::ETA_MAX});
              state <= ST_STORE;
            end else begin
              root_n <= sq_xy + sq_z;
              rem_r  <= '0;
              root   <= '0;
              root_p <= 1'b1;
              state  <= ST_ROOT;
            end
          end
        end
        ST_LOGI: begin
          log_k <= log_k0;
          log_y <= 31'({6'b0, log_src} << (5'd30 - log_k0));
          frac  <= '0;
          cnt   <= '0;
          state <= ST_LOG;
        end
        ST_LOG: begin
          log_y <= log_y_next;
          frac  <= frac_next;
          cnt   <= cnt + 1'b1;
          if (cnt == 6'd15) begin
            cnt <= '0;
            if (!log_sel) begin
              la      <= {log_k, frac_next};
              log_sel <= 1'b1;
              state   <= ST_LOGI;
            end else begin
              state <= ST_ETA;
            end
          end
        end
        ST_ETA: begin
          eta_r <= eta_next;
          cnt   <= '0;
          state <= (item.action == tics_pkg::ACT_REF) ? ST_STORE : ST_DR;
        end
        ST_STORE: begin
          ref_eta <= eta_r;
          ref_phi <= phi_r;
          ref_pt  <= pt_r;
          acc     <= '0;
          clip    <= 1'b0;
          state   <= ST_IDLE;
        end
        ST_DR: begin
          cnt <= cnt + 1'b1;
          case (cnt[1:0])
            2'd0:    dr2 <= dr_prod[34:0];
            2'd1:    dr2 <= dr2 + dr_prod[34:0];
            2'd2:    o2  <= dr_prod[31:0];
            default: begin
              i2    <= dr_prod[31:0];
              cnt   <= '0;
              state <= ST_ACC;
            end
          endcase
        end
        ST_ACC: begin
          if (dr2 < {3'b0, o2} && dr2 > {3'b0, i2}) begin
            if (acc_sum[32]) begin
              acc  <= tics_pkg::U32_MAX;
              clip <= 1'b1;
            end else begin
              acc <= acc_sum[31:0];
            end
          end
          state <= item.last_track ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          cnt <= '0;
          if (!cfg.relative_mode) begin
            res_r <= acc;
            sat_r <= clip;
            state <= ST_OUT;
          end else if (ref_pt == '0) begin
            res_r <= tics_pkg::U32_MAX;
            sat_r <= 1'b1;
            state <= ST_OUT;
          end else begin
            div_n   <= {acc, 16'b0};
            div_q   <= '0;
            div_rem <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_n   <= {div_n[46:0], 1'b0};
          div_q   <= div_q_next;
          div_rem <= div_rem_next;
          cnt     <= cnt + 1'b1;
          if (cnt == 6'd47) begin
            cnt <= '0;
            if (div_q_next[47:32] != '0) begin
              res_r <= tics_pkg::U32_MAX;
              sat_r <= 1'b1;
            end else begin
              res_r <= div_q_next[31:0];
              sat_r <= clip;
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            acc   <= '0;
            clip  <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum <= res_r;
      out_iso <= (acc <= cfg.isolation_cut);
      out_sat <= sat_r;
    end
  end

endmodule

>>> rtl/core/track_isolation_cone_sum.sv
// track_isolation_cone_sum: top level, config registers, front stage, queue, sequencer
// depends on tics_pkg, tics_front, tics_queue, tics_back
//
//  channel  dir  payload
//  s_axis   in   tdata = mom_x, mom_y, mom_z; tuser = action; tlast = last_track
//  m_axis   out  tdata = cone_sum; tuser = isolated, saturated
//  cfg      in   cfg_addr selects outer, inner, relative mode, cut
//
// a reference track runs the 24 step square root for pt, the 16 step cordic, the
// square root for p and two 16 step log2 loops, or stops after the cordic at zero pt.
// a candidate in range runs the same plus the deltaR terms, one below the pt threshold
// only the first root. a finish beat or a last track ends the sum; relative mode adds the
// divider. rst is synchronous and clears control state and the config to its defaults.
// the front stage and a 4 beat queue keep taking beats while the sequencer works.
// a result waits in the output register and stalls only the sequencer.
module track_isolation_cone_sum (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // mom_x, mom_y, mom_z
  input  logic [1:0]  s_axis_tuser,   // action
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // cone_sum
  output logic [1:0]  m_axis_tuser,   // isolated, saturated
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  tics_pkg::cfg_t    cfg;
  logic              q_push;
  tics_pkg::item_t   q_push_item;
  logic              q_pop;
  logic              q_valid;
  tics_pkg::item_t   q_item;
  tics_pkg::q_stat_t q_stat;
  logic              out_iso;
  logic              out_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.outer_radius  <= 16'd819;
      cfg.inner_radius  <= 16'd61;
      cfg.relative_mode <= 1'b0;
      cfg.isolation_cut <= '0;
    end else if (cfg_wr_en) begin
      unique case (tics_pkg::cfg_reg_t'(cfg_addr))
        tics_pkg::REG_OUTER:    cfg.outer_radius  <= cfg_wdata[15:0];
        tics_pkg::REG_INNER:    cfg.inner_radius  <= cfg_wdata[15:0];
        tics_pkg::REG_RELATIVE: cfg.relative_mode <= cfg_wdata[0];
        tics_pkg::REG_CUT:      cfg.isolation_cut <= cfg_wdata;
        default:                cfg.isolation_cut <= cfg.isolation_cut;
      endcase
    end
  end

  tics_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .in_last   (s_axis_tlast),
    .push      (q_push),
    .push_item (q_push_item),
    .q_stat    (q_stat)
  );

  tics_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .stat      (q_stat)
  );

  tics_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_sum   (m_axis_tdata),
    .out_iso   (out_iso),
    .out_sat   (out_sat)
  );

  assign m_axis_tuser = {out_sat, out_iso};

  // absolute mode: a clipped sum reads as all ones
  a_abs_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !cfg.relative_mode && m_axis_tuser[1] |-> m_axis_tdata == 32'hFFFF_FFFF)
    else $error("clipped absolute sum is not all ones");

  // absolute mode: flag agrees with the reported sum
  a_abs_iso: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !cfg.relative_mode |-> m_axis_tuser[0] == (m_axis_tdata <= cfg.isolation_cut))
    else $error("isolated flag disagrees with sum");

  a_q_push: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

>>> tb/tb.sv
// tb: self-checking bench for track_isolation_cone_sum, annulus pt sum with isolation flag
// depends on tics_pkg and the rtl; carries its own bit-true predictor of the block
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 800;
  localparam int HOLD_CYCLES    = 400;
  localparam longint MOM_MAX    = 64'sd8388607;
  localparam longint MOM_MIN    = -64'sd8388608;

  typedef struct {
    logic [31:0] sum;
    logic        iso;
    logic        sat;
  } cone_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // mom_x, mom_y, mom_z
  logic [1:0]  s_axis_tuser = '0;   // action
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // cone_sum
  logic [1:0]  m_axis_tuser;        // isolated, saturated
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  track_isolation_cone_sum dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] p_outer, p_inner;
  logic        p_relative;
  logic [31:0] p_cut;
  longint      ref_eta, ref_phi;
  longint unsigned ref_pt, pt_sum;
  bit          sum_clipped;

  cone_result_t expected_q[$];
  int errors, beats_in, results_seen, hold_reqs, watchdog;
  bit no_idle;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log2_q16(longint unsigned x);
    int k;
    longint unsigned y, frac;
    k = 0;
    frac = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    y = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac <<= 1;
      if (y >= (64'd1 << 31)) begin
        frac |= 1;
        y >>= 1;
      end
    end
    return (longint'(k) << 16) | frac;
  endfunction

  function automatic longint azimuth(longint px, longint py);
    longint x, y, z, xn, r;
    longint atan_steps[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2};
    if (px == 0 && py == 0) return 0;
    z = 0;
    if (px < 0) begin
      x = -px;
      y = -py;
      z = (py >= 0) ? 205887 : -205887;
    end else begin
      x = px;
      y = py;
    end
    x *= 256;
    y *= 256;
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_steps[i];
      end else begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_steps[i];
      end
      x = xn;
    end
    r = (z + 8) >>> 4;
    if (r > 12868) r = 12868;
    if (r < -12868) r = -12868;
    return r;
  endfunction

  function automatic longint pseudorapidity(longint px, longint py, longint pz,
                                            longint unsigned pt);
    longint unsigned apz, p, mag;
    longint d;
    if (pt == 0) return pz > 0 ? 32767 : (pz < 0 ? -32767 : 0);
    apz = pz < 0 ? -pz : pz;
    p = int_sqrt(px * px + py * py + apz * apz);
    d = longint'(log2_q16(apz + p)) - longint'(log2_q16(pt));
    if (d < 0) d = 0;
    mag = (longint'(d) * 45426) >> 20;
    if (mag > 32767) mag = 32767;
    return pz < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  // advances the predictor by one accepted beat, queues the result if any
  function automatic void predict_cone(tics_pkg::action_t act, logic [23:0] bx,
                                       logic [23:0] by, logic [23:0] bz, logic last);
    longint px, py, pz, deta, dphi;
    longint unsigned pt, dr2, s, res;
    cone_result_t r;
    px = longint'($signed(bx));
    py = longint'($signed(by));
    pz = longint'($signed(bz));
    if (act == tics_pkg::ACT_IGNORE) return;
    pt = int_sqrt(px * px + py * py);
    if (act == tics_pkg::ACT_REF) begin
      ref_pt = pt & 64'hFFFFFF;
      ref_phi = azimuth(px, py);
      ref_eta = pseudorapidity(px, py, pz, pt);
      pt_sum = 0;
      sum_clipped = 0;
      return;
    end
    if (act == tics_pkg::ACT_CAND) begin
      if (pt >= 256) begin
        deta = pseudorapidity(px, py, pz, pt) - ref_eta;
        dphi = azimuth(px, py) - ref_phi;
        if (dphi > 12868) dphi -= 25736;
        if (dphi < -12868) dphi += 25736;
        dr2 = deta * deta + dphi * dphi;
        if (dr2 < longint'(p_outer) * p_outer && dr2 > longint'(p_inner) * p_inner) begin
          s = pt_sum + pt;
          if (s > 64'hFFFF_FFFF) begin
            s = 64'hFFFF_FFFF;
            sum_clipped = 1;
          end
          pt_sum = s;
        end
      end
      if (!last) return;
    end
    r.sat = sum_clipped;
    if (p_relative) begin
      if (ref_pt == 0) begin
        res = 64'hFFFF_FFFF;
        r.sat = 1;
      end else begin
        res = (pt_sum << 16) / ref_pt;
        if (res > 64'hFFFF_FFFF) begin
          res = 64'hFFFF_FFFF;
          r.sat = 1;
        end
      end
    end else res = pt_sum;
    r.sum = res[31:0];
    r.iso = pt_sum <= p_cut;
    expected_q.push_back(r);
    pt_sum = 0;
    sum_clipped = 0;
  endfunction

  task automatic report(string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [23:0] clamp24(longint v);
    if (v > MOM_MAX) return MOM_MAX[23:0];
    if (v < MOM_MIN) return MOM_MIN[23:0];
    return v[23:0];
  endfunction

  task automatic send_track(tics_pkg::action_t act, longint x, longint y, longint z,
                            logic last);
    logic [23:0] bx, by, bz;
    bx = clamp24(x);
    by = clamp24(y);
    bz = clamp24(z);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {bz, by, bx};
    s_axis_tuser <= act;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    predict_cone(act, bx, by, bz, last);
    beats_in++;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves the write enable high, set_config drops it after the last write
  task automatic write_reg(tics_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      tics_pkg::REG_OUTER:    p_outer = val[15:0];
      tics_pkg::REG_INNER:    p_inner = val[15:0];
      tics_pkg::REG_RELATIVE: p_relative = val[0];
      default:                p_cut = val;
    endcase
  endtask

  task automatic set_config(logic [15:0] outer, logic [15:0] inner, logic rel,
                            logic [31:0] cut);
    stop_sending();
    wait_drained();
    write_reg(tics_pkg::REG_OUTER, outer);
    write_reg(tics_pkg::REG_INNER, inner);
    write_reg(tics_pkg::REG_RELATIVE, rel);
    write_reg(tics_pkg::REG_CUT, cut);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic longint rand_mom();
    longint v;
    v = longint'($signed(24'($urandom)));
    return v >>> $urandom_range(0, 16);
  endfunction

  function automatic longint nudge(longint v);
    longint span;
    span = (v < 0 ? -v : v) / 6 + 4;
    return v + longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // --- tests

  task automatic test_directed();
    send_track(tics_pkg::ACT_CAND, 3000, 200, 100, 1'b1);          // no reference loaded yet
    send_track(tics_pkg::ACT_REF, 0, 0, 5000, 1'b1);               // zero pt, last ignored
    send_track(tics_pkg::ACT_FIN, 0, 0, 0, 1'b1);
    send_track(tics_pkg::ACT_REF, 0, 0, -5000, 1'b0);
    send_track(tics_pkg::ACT_REF, 0, 0, 0, 1'b0);
    send_track(tics_pkg::ACT_REF, 4000, 300, 2000, 1'b0);
    send_track(tics_pkg::ACT_CAND, 4000, 500, 2100, 1'b0);
    send_track(tics_pkg::ACT_CAND, 100, 50, 20, 1'b0);             // below pt threshold
    send_track(tics_pkg::ACT_IGNORE, 4000, 500, 2100, 1'b1);       // ignored beat
    send_track(tics_pkg::ACT_CAND, 4100, 200, 1900, 1'b1);
    send_track(tics_pkg::ACT_REF, MOM_MIN, 1000, MOM_MAX, 1'b0);   // phi near +pi
    send_track(tics_pkg::ACT_CAND, MOM_MIN, -1000, MOM_MAX, 1'b0); // phi near -pi, wraps
    send_track(tics_pkg::ACT_CAND, MOM_MAX, MOM_MAX, MOM_MIN, 1'b0);
    send_track(tics_pkg::ACT_CAND, MOM_MIN, MOM_MIN, MOM_MIN, 1'b1);
    send_track(tics_pkg::ACT_FIN, -1, -1, -1, 1'b0);
  endtask

  task automatic test_relative_edges();
    set_config(16'd65535, 16'd0, 1'b1, 32'hFFFF_FFFF);
    send_track(tics_pkg::ACT_REF, 0, 0, 777, 1'b0);                // zero reference pt
    send_track(tics_pkg::ACT_CAND, 5000, 100, 0, 1'b1);
    send_track(tics_pkg::ACT_REF, 256, 0, 0, 1'b0);                // large ratio, still fits in 32 bits
    send_track(tics_pkg::ACT_CAND, MOM_MAX, 100000, 0, 1'b1);
    send_track(tics_pkg::ACT_REF, 3000, 3000, 100, 1'b0);
    send_track(tics_pkg::ACT_CAND, 3100, 2900, 120, 1'b1);
  endtask

  task automatic test_sum_overflow();
    set_config(16'd65535, 16'd0, 1'b0, 32'd0);
    send_track(tics_pkg::ACT_REF, MOM_MAX, 0, 0, 1'b0);
    for (int i = 0; i < 370; i++)
      send_track(tics_pkg::ACT_CAND, MOM_MAX, MOM_MAX, 0, i == 369);
  endtask

  task automatic test_backpressure();
    hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < 12; i++) send_track(tics_pkg::ACT_FIN, 0, 0, 0, 1'b0);
  endtask

  task automatic random_phase(int n);
    longint rx, ry, rz;
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_track(tics_pkg::action_t'($urandom_range(0, 3)),
                   longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
                   longint'($signed(24'($urandom))), 1'($urandom));
        k++;
      end else begin
        rx = rand_mom();
        ry = rand_mom();
        rz = rand_mom();
        send_track(tics_pkg::ACT_REF, rx, ry, rz, 1'b0);
        k++;
        for (int c = $urandom_range(0, 6); c >= 0; c--) begin
          if ($urandom_range(0, 4) == 0)
            send_track(tics_pkg::ACT_CAND, rand_mom(), rand_mom(), rand_mom(), c == 0);
          else
            send_track(tics_pkg::ACT_CAND, nudge(rx), nudge(ry), nudge(rz), c == 0);
          k++;
        end
        if ($urandom_range(0, 3) == 0) begin
          send_track(tics_pkg::ACT_FIN, 0, 0, 0, 1'($urandom));
          k++;
        end
      end
    end
  endtask

  // --- result checking and output stalls
  int hold_seen, hold_left, burst_left;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result beat sum=%h", m_axis_tdata));
        end else begin
          cone_result_t e;
          e = expected_q.pop_front();
          if (m_axis_tdata !== e.sum)
            report($sformatf("cone_sum got %h want %h", m_axis_tdata, e.sum));
          if (m_axis_tuser[0] !== e.iso)
            report($sformatf("isolated got %b want %b", m_axis_tuser[0], e.iso));
          if (m_axis_tuser[1] !== e.sat)
            report($sformatf("saturated got %b want %b", m_axis_tuser[1], e.sat));
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      watchdog = 0;
    else
      watchdog++;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired with %0d results outstanding", expected_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    p_outer = 16'd819;
    p_inner = 16'd61;
    p_relative = 1'b0;
    p_cut = 32'd0;
    ref_eta = 0;
    ref_phi = 0;
    ref_pt = 0;
    pt_sum = 0;
    sum_clipped = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_relative_edges();
    test_sum_overflow();
    set_config(16'd819, 16'd61, 1'b0, 32'd40000);
    test_backpressure();
    random_phase(130);
    set_config(16'd4000, 16'd0, 1'b1, 32'd0);
    random_phase(110);
    set_config(16'd0, 16'd65535, 1'b0, 32'hFFFF_FFFF);
    random_phase(40);
    set_config(16'd1500, 16'd100, 1'b0, 32'h0010_0000);
    no_idle = 1;
    random_phase(140);
    stop_sending();

    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d beats sent, %0d results checked, %0d mismatches",
             beats_in, results_seen, errors);
    $display("tb: covered zero-pt and wrapped references, clipping, ratios and stalls");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
